@@ rtl/pjlm_pkg.sv @@
// Package for the packet jitter and loss monitor.
// Holds field widths, reset constants, shared types and the saturating subtract.
// Depends on nothing; the modules and the testbench import it.
`timescale 1ns / 1ps

package pjlm_pkg;

   localparam int SEQ_W    = 31;
   localparam int MARKER_W = 32;
   localparam int TIME_W   = 64;
   localparam int CNT_W    = 32;
   localparam int LOSS_W   = 33;
   localparam int DLOSS_W  = 34;
   localparam int JIT_W    = 31;
   localparam int PEAK_W   = 32;

   localparam logic [0:0] OP_PACKET = 1'b0;
   localparam logic [0:0] OP_TICK   = 1'b1;

   localparam logic [MARKER_W-1:0]      MARKER_RESET = 32'h0000_1234;
   localparam logic [CNT_W-1:0]         CNT_SAT      = 32'hFFFF_FFFF;
   localparam logic [JIT_W-1:0]         JIT_SAT      = 31'h7FFF_FFFF;
   localparam logic signed [PEAK_W-1:0] PEAK_NONE    = -32'sd1;
   localparam logic signed [TIME_W-1:0] SPREAD_TOP   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [TIME_W-1:0] SPREAD_BOTTOM = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [0:0]               operation;
      logic [SEQ_W-1:0]         seq_num;
      logic                     mark_ok;
      logic signed [TIME_W-1:0] send_time;
      logic signed [TIME_W-1:0] recv_time;
   } item_type;

   typedef struct packed {
      logic                     valid;
      logic [SEQ_W-1:0]         seq_num;
      logic signed [TIME_W-1:0] send_time;
      logic signed [TIME_W-1:0] recv_time;
   } slot_type;

   typedef struct packed {
      logic                     valid;
      logic                     is_tick;
      logic                     next_hit;
      logic                     prev_hit;
      logic signed [TIME_W-1:0] next_spread;
      logic signed [TIME_W-1:0] prev_spread;
   } pair_type;

   typedef struct packed {
      logic                     valid;
      logic [CNT_W-1:0]         total;
      logic [CNT_W-1:0]         fresh;
      logic signed [LOSS_W-1:0] loss;
      logic signed [LOSS_W-1:0] prev_loss;
      logic [TIME_W-1:0]        span;
      logic                     had_pair;
   } tick_type;

   function automatic logic signed [TIME_W-1:0] sat_sub64(
      input logic signed [TIME_W-1:0] a,
      input logic signed [TIME_W-1:0] b
   );
      logic signed [TIME_W-1:0] r;
      r = a - b;
      if ((a[TIME_W-1] != b[TIME_W-1]) && (r[TIME_W-1] != a[TIME_W-1])) begin
         return a[TIME_W-1] ? SPREAD_BOTTOM : SPREAD_TOP;
      end
      return r;
   endfunction

endpackage

@@ rtl/pjlm_req_if.sv @@
// Request channel of the monitor: valid/ready handshake with one item per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface pjlm_req_if;
   logic               valid;
   logic               ready;
   logic [0:0]         operation;
   logic [30:0]        seq_num;
   logic [31:0]        marker;
   logic signed [63:0] send_time;
   logic signed [63:0] recv_time;

   modport source (
      output valid, operation, seq_num, marker, send_time, recv_time,
      input  ready
   );
   modport sink (
      input  valid, operation, seq_num, marker, send_time, recv_time,
      output ready
   );
endinterface

@@ rtl/pjlm_rsp_if.sv @@
// Response channel of the monitor: valid/ready handshake carrying one report.
// Depends on nothing.
`timescale 1ns / 1ps

interface pjlm_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        total_packets;
   logic [31:0]        new_packets;
   logic signed [32:0] loss;
   logic signed [33:0] loss_change;
   logic [30:0]        window_jitter;
   logic signed [31:0] peak_jitter;
   logic               window_had_pair;

   modport source (
      output valid, total_packets, new_packets, loss, loss_change, window_jitter,
             peak_jitter, window_had_pair,
      input  ready
   );
   modport sink (
      input  valid, total_packets, new_packets, loss, loss_change, window_jitter,
             peak_jitter, window_had_pair,
      output ready
   );
endinterface

@@ rtl/packet_jitter_loss_monitor.sv @@
// Top level of the packet jitter and loss monitor.
// Instantiates the index pipeline, the ring, the statistics and the report stage.
// Depends on pjlm_pkg, pjlm_req_if, pjlm_rsp_if and the pjlm_* modules.
//
// Usage: the request channel carries packet and tick transactions. A packet whose marker
// matches the marker register is stored in the ring slot given by its sequence number
// modulo RING_DEPTH and checked against both neighbor slots. A tick produces one
// transaction on the response channel when matching packets came since the last report,
// and nothing otherwise. The marker register is written through csr_we and csr_wdata.
// After reset the ring is swept clean, one slot per cycle, with req_port.ready low; csr
// writes are taken throughout. Otherwise throughput is one transaction per cycle unless
// stalled: the ring memory reads both neighbors in the same cycle it writes the slot of
// the previous packet, with forwarding between them. A tick's report is registered in
// the index, ring and stats stages before the response register. When the receiver
// stalls, the finished report waits in the response register and requests keep flowing
// until a second report reaches the last stage; only then does the whole pipeline hold.
`timescale 1ns / 1ps

module packet_jitter_loss_monitor
   import pjlm_pkg::*;
#(
   parameter int RING_DEPTH = 8192
) (
   input  logic          clock,
   input  logic          reset,
   pjlm_req_if.sink      req_port,
   pjlm_rsp_if.source    rsp_port,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);

   logic [MARKER_W-1:0] marker_ff;
   logic                adv, stall, clearing, accept;
   item_type            req_item;
   logic                ix_valid;
   item_type            ix_item;
   logic [AW-1:0]       ix_cell;
   pair_type            pair_bus;
   tick_type            tick_bus;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else if (csr_we) begin
         marker_ff <= csr_wdata;
      end
   end

   always_comb begin
      adv            = !stall;
      req_port.ready = !clearing && !stall;
      accept         = req_port.valid && req_port.ready;
      req_item.operation = req_port.operation;
      req_item.seq_num   = req_port.seq_num;
      req_item.mark_ok   = (req_port.marker == marker_ff);
      req_item.send_time = req_port.send_time;
      req_item.recv_time = req_port.recv_time;
   end

   pjlm_index #(.RING_DEPTH(RING_DEPTH)) u_index (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (ix_valid),
      .out_item  (ix_item),
      .out_cell  (ix_cell)
   );

   pjlm_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (ix_valid),
      .in_item  (ix_item),
      .in_cell  (ix_cell),
      .clearing (clearing),
      .pair_out (pair_bus)
   );

   pjlm_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .pair_in  (pair_bus),
      .tick_out (tick_bus)
   );

   pjlm_report u_report (
      .clock    (clock),
      .reset    (reset),
      .tick_in  (tick_bus),
      .stall    (stall),
      .rsp_port (rsp_port)
   );

endmodule

@@ rtl/pjlm_index.sv @@
// Slot index pipeline: three stages that reduce the sequence number modulo the ring depth.
// Uses a reciprocal multiply, a back multiply and one correction. Depends on pjlm_pkg.
`timescale 1ns / 1ps

module pjlm_index
   import pjlm_pkg::*;
#(
   parameter int RING_DEPTH = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  item_type                      in_item,
   output logic                          out_valid,
   output item_type                      out_item,
   output logic [$clog2(RING_DEPTH)-1:0] out_cell
);

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int RW    = AW + 1;
   localparam int LD    = $clog2(RING_DEPTH + 1) - 1;
   localparam int SHIFT = SEQ_W + LD;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(RING_DEPTH);
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
   localparam logic [RW-1:0] DEPTH_R = RW'(RING_DEPTH);

   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff;
   item_type        s1_item_ff, s2_item_ff, s3_item_ff;
   logic [62:0]     s1_prod_ff;
   logic [47:0]     s2_prod_ff;
   logic [AW-1:0]   s3_cell_ff;
   logic [SEQ_W-1:0] quot;
   logic [RW-1:0]   rem;
   logic [RW-1:0]   rem_fix;

   always_comb begin
      quot    = SEQ_W'(s1_prod_ff >> SHIFT);
      rem     = s2_item_ff.seq_num[RW-1:0] - s2_prod_ff[RW-1:0];
      rem_fix = (rem >= DEPTH_R) ? rem - DEPTH_R : rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= in_item;
         s1_prod_ff <= 63'(in_item.seq_num) * 63'(RECIP);
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= 48'(quot) * 48'(RING_DEPTH);
         s3_item_ff <= s2_item_ff;
         s3_cell_ff <= rem_fix[AW-1:0];
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;
   assign out_cell  = s3_cell_ff;

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (32'(s3_cell_ff) < 32'(RING_DEPTH)))
      else $error("slot index out of range");

   a_rem_single_fix: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (rem_fix < DEPTH_R))
      else $error("remainder needs more than one correction");

   a_cell_matches: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff) |=> (32'(s3_cell_ff) == 32'(s3_item_ff.seq_num) % RING_DEPTH))
      else $error("slot index differs from sequence modulo depth");

endmodule

@@ rtl/pjlm_ring.sv @@
// Ring memory of stored packets with its clearing sweep, neighbor reads and forwarding.
// Finds consecutive pairs and their spreads. Depends on pjlm_pkg.
`timescale 1ns / 1ps

module pjlm_ring
   import pjlm_pkg::*;
#(
   parameter int RING_DEPTH = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  item_type                      in_item,
   input  logic [$clog2(RING_DEPTH)-1:0] in_cell,
   output logic                          clearing,
   output pair_type                      pair_out
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   slot_type      slot_ram_ff [RING_DEPTH];
   slot_type      rd_next_ff, rd_prev_ff;
   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          b_valid_ff;
   item_type      b_item_ff;
   logic [AW-1:0] b_cell_ff, b_next_ff, b_prev_ff;
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   slot_type      fwd_data_ff;
   pair_type      pair_ff;

   logic [AW-1:0] next_addr, prev_addr;
   slot_type      next_slot, prev_slot;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data;
   pair_type      pair_in;

   always_comb begin
      next_addr = (in_cell == LAST) ? '0 : in_cell + AW'(1);
      prev_addr = (in_cell == '0) ? LAST : in_cell - AW'(1);

      next_slot = (fwd_valid_ff && fwd_addr_ff == b_next_ff) ? fwd_data_ff : rd_next_ff;
      prev_slot = (fwd_valid_ff && fwd_addr_ff == b_prev_ff) ? fwd_data_ff : rd_prev_ff;

      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = adv && b_valid_ff && (b_item_ff.operation == OP_PACKET) && b_item_ff.mark_ok;
         wr_addr = b_cell_ff;
         wr_data = '{valid: 1'b1, seq_num: b_item_ff.seq_num,
                     send_time: b_item_ff.send_time, recv_time: b_item_ff.recv_time};
      end

      pair_in.valid    = b_valid_ff &&
                         ((b_item_ff.operation == OP_TICK) || b_item_ff.mark_ok);
      pair_in.is_tick  = (b_item_ff.operation == OP_TICK);
      pair_in.next_hit = next_slot.valid &&
                         ({1'b0, b_item_ff.seq_num} + 32'd1 == {1'b0, next_slot.seq_num});
      pair_in.prev_hit = prev_slot.valid &&
                         ({1'b0, prev_slot.seq_num} + 32'd1 == {1'b0, b_item_ff.seq_num});
      pair_in.next_spread = sat_sub64(b_item_ff.recv_time, next_slot.send_time);
      pair_in.prev_spread = sat_sub64(prev_slot.recv_time, b_item_ff.send_time);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram_ff[wr_addr] <= wr_data;
      end
      if (adv && in_valid) begin
         rd_next_ff <= slot_ram_ff[next_addr];
         rd_prev_ff <= slot_ram_ff[prev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         pair_ff.valid <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST) begin
               clear_ff <= 1'b0;
            end
         end
         if (adv || clear_ff) begin
            fwd_valid_ff <= wr_en;
         end
         if (adv) begin
            b_valid_ff    <= in_valid;
            pair_ff.valid <= pair_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv || clear_ff) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      if (adv) begin
         b_item_ff <= in_item;
         b_cell_ff <= in_cell;
         b_next_ff <= next_addr;
         b_prev_ff <= prev_addr;
         pair_ff.is_tick     <= pair_in.is_tick;
         pair_ff.next_hit    <= pair_in.next_hit;
         pair_ff.prev_hit    <= pair_in.prev_hit;
         pair_ff.next_spread <= pair_in.next_spread;
         pair_ff.prev_spread <= pair_in.prev_spread;
      end
   end

   assign clearing = clear_ff;
   assign pair_out = pair_ff;

   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !b_valid_ff && !in_valid)
      else $error("transaction reached the ring during the clearing sweep");

   a_neighbors_apart: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_next_ff != b_cell_ff) && (b_prev_ff != b_cell_ff))
      else $error("neighbor slot aliases own slot");

endmodule

@@ rtl/pjlm_stats.sv @@
// Running statistics: packet and pair counts, window spread extremes and report bookkeeping.
// Turns a tick with new packets into a report record. Depends on pjlm_pkg.
`timescale 1ns / 1ps

module pjlm_stats
   import pjlm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  pair_type pair_in,
   output tick_type tick_out
);

   logic [CNT_W-1:0]         pkt_cnt_ff, pair_cnt_ff, reported_ff;
   logic signed [TIME_W-1:0] min_ff, max_ff;
   logic signed [LOSS_W-1:0] prev_loss_ff;
   logic                     restart_ff;
   tick_type                 tick_ff;

   logic signed [TIME_W-1:0] eff_min, eff_max, min_in, max_in;
   logic                     n_lt, p_lt, pn_lt, n_gt, p_gt, pn_gt;
   logic [CNT_W:0]           pair_sum;
   logic [DLOSS_W-1:0]       loss_wide;
   logic                     is_pkt, is_new_tick;
   tick_type                 tick_in;

   always_comb begin
      eff_min = restart_ff ? SPREAD_TOP : min_ff;
      eff_max = restart_ff ? SPREAD_BOTTOM : max_ff;
      n_lt  = pair_in.next_spread < eff_min;
      p_lt  = pair_in.prev_spread < eff_min;
      pn_lt = pair_in.prev_spread < pair_in.next_spread;
      n_gt  = pair_in.next_spread > eff_max;
      p_gt  = pair_in.prev_spread > eff_max;
      pn_gt = pair_in.prev_spread > pair_in.next_spread;

      case ({pair_in.next_hit, pair_in.prev_hit})
         2'b10: begin
            min_in = n_lt ? pair_in.next_spread : eff_min;
            max_in = n_gt ? pair_in.next_spread : eff_max;
         end
         2'b01: begin
            min_in = p_lt ? pair_in.prev_spread : eff_min;
            max_in = p_gt ? pair_in.prev_spread : eff_max;
         end
         2'b11: begin
            if (pn_lt) begin
               min_in = p_lt ? pair_in.prev_spread : eff_min;
            end else begin
               min_in = n_lt ? pair_in.next_spread : eff_min;
            end
            if (pn_gt) begin
               max_in = p_gt ? pair_in.prev_spread : eff_max;
            end else begin
               max_in = n_gt ? pair_in.next_spread : eff_max;
            end
         end
         default: begin
            min_in = eff_min;
            max_in = eff_max;
         end
      endcase

      pair_sum  = {1'b0, pair_cnt_ff} + (CNT_W + 1)'(pair_in.next_hit)
                + (CNT_W + 1)'(pair_in.prev_hit);
      loss_wide = {2'b00, pkt_cnt_ff} + {2'b11, ~pair_cnt_ff};

      is_pkt      = pair_in.valid && !pair_in.is_tick;
      is_new_tick = pair_in.valid && pair_in.is_tick && (reported_ff != pkt_cnt_ff);

      tick_in.valid     = is_new_tick;
      tick_in.total     = pkt_cnt_ff;
      tick_in.fresh     = pkt_cnt_ff - reported_ff;
      tick_in.loss      = loss_wide[LOSS_W-1:0];
      tick_in.prev_loss = prev_loss_ff;
      tick_in.span      = max_ff - min_ff;
      tick_in.had_pair  = max_ff >= min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_cnt_ff   <= '0;
         pair_cnt_ff  <= '0;
         reported_ff  <= '0;
         min_ff       <= SPREAD_TOP;
         max_ff       <= SPREAD_BOTTOM;
         prev_loss_ff <= '0;
         restart_ff   <= 1'b1;
         tick_ff.valid <= 1'b0;
      end else if (adv) begin
         tick_ff.valid <= tick_in.valid;
         if (is_pkt) begin
            restart_ff  <= 1'b0;
            pkt_cnt_ff  <= (pkt_cnt_ff == CNT_SAT) ? pkt_cnt_ff : pkt_cnt_ff + CNT_W'(1);
            pair_cnt_ff <= pair_sum[CNT_W] ? CNT_SAT : pair_sum[CNT_W-1:0];
            min_ff      <= min_in;
            max_ff      <= max_in;
         end
         if (is_new_tick) begin
            restart_ff   <= 1'b1;
            reported_ff  <= pkt_cnt_ff;
            prev_loss_ff <= tick_in.loss;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tick_ff.total     <= tick_in.total;
         tick_ff.fresh     <= tick_in.fresh;
         tick_ff.loss      <= tick_in.loss;
         tick_ff.prev_loss <= tick_in.prev_loss;
         tick_ff.span      <= tick_in.span;
         tick_ff.had_pair  <= tick_in.had_pair;
      end
   end

   assign tick_out = tick_ff;

   a_restart_cleared_by_packet: assert property (@(posedge clock) disable iff (reset)
      !restart_ff |-> (pkt_cnt_ff != '0))
      else $error("window armed without any packet");

   a_reported_not_ahead: assert property (@(posedge clock) disable iff (reset)
      reported_ff <= pkt_cnt_ff)
      else $error("reported count exceeds packet count");

   a_pairs_bounded: assert property (@(posedge clock) disable iff (reset)
      (adv && is_pkt && pair_cnt_ff < pkt_cnt_ff) |=> (pair_cnt_ff <= pkt_cnt_ff + 32'd1))
      else $error("pair count ran ahead of packets");

endmodule

@@ rtl/pjlm_report.sv @@
// Report stage and output register: loss change, window jitter and the jitter peak.
// Drives the response channel. Depends on pjlm_pkg and pjlm_rsp_if.
`timescale 1ns / 1ps

module pjlm_report
   import pjlm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tick_type          tick_in,
   output logic              stall,
   pjlm_rsp_if.source        rsp_port
);

   logic signed [PEAK_W-1:0]  peak_ff, peak_in;
   logic                      rsp_valid_ff;
   logic [CNT_W-1:0]          total_ff, fresh_ff;
   logic signed [LOSS_W-1:0]  loss_ff;
   logic signed [DLOSS_W-1:0] dloss_ff, dloss_in;
   logic [JIT_W-1:0]          jit_ff, jit_in;
   logic                      had_ff;
   logic                      load;

   always_comb begin
      dloss_in = {tick_in.loss[LOSS_W-1], tick_in.loss}
               - {tick_in.prev_loss[LOSS_W-1], tick_in.prev_loss};
      if (!tick_in.had_pair) begin
         jit_in = '0;
      end else if (tick_in.span[TIME_W-1:JIT_W] != '0) begin
         jit_in = JIT_SAT;
      end else begin
         jit_in = tick_in.span[JIT_W-1:0];
      end
      peak_in = (tick_in.had_pair && $signed({1'b0, jit_in}) > peak_ff) ?
                $signed({1'b0, jit_in}) : peak_ff;
      stall = tick_in.valid && rsp_valid_ff && !rsp_port.ready;
      load  = tick_in.valid && !stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= PEAK_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            peak_ff      <= peak_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         total_ff <= tick_in.total;
         fresh_ff <= tick_in.fresh;
         loss_ff  <= tick_in.loss;
         dloss_ff <= dloss_in;
         jit_ff   <= jit_in;
         had_ff   <= tick_in.had_pair;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.total_packets   = total_ff;
   assign rsp_port.new_packets     = fresh_ff;
   assign rsp_port.loss            = loss_ff;
   assign rsp_port.loss_change     = dloss_ff;
   assign rsp_port.window_jitter   = jit_ff;
   assign rsp_port.peak_jitter     = peak_ff;
   assign rsp_port.window_had_pair = had_ff;

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (peak_ff >= $past(peak_ff)))
      else $error("jitter peak decreased");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff && (!had_ff || (peak_ff >= $signed({1'b0, jit_ff}))))
      else $error("loaded report missing or peak below window jitter");

   a_no_jitter_without_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !had_ff) |-> (jit_ff == '0))
      else $error("jitter reported for a window without pairs");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for packet_jitter_loss_monitor.
// Drives packet and tick transactions, predicts each report and compares it field by field.
// Depends on pjlm_pkg, pjlm_req_if, pjlm_rsp_if and the monitor RTL.
`timescale 1ns / 1ps

module testbench;
   import pjlm_pkg::*;

   localparam int RING          = 8192;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_CYCLES  = 400;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int PHASE_EVENTS  = 325;

   typedef struct {
      logic [0:0]               op;
      logic [SEQ_W-1:0]         seq;
      logic [MARKER_W-1:0]      marker;
      logic signed [TIME_W-1:0] sent;
      logic signed [TIME_W-1:0] rcvd;
   } flow_event_type;

   typedef struct {
      logic [CNT_W-1:0]   total;
      logic [CNT_W-1:0]   fresh;
      logic [LOSS_W-1:0]  loss;
      logic [DLOSS_W-1:0] loss_delta;
      logic [JIT_W-1:0]   jitter;
      logic [PEAK_W-1:0]  peak;
      logic               had_pair;
   } flow_report_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;

   pjlm_req_if req_bus ();
   pjlm_rsp_if rsp_bus ();

   packet_jitter_loss_monitor #(.RING_DEPTH(RING)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   flow_event_type  pending_events[$];
   flow_report_type expected_reports[$];
   flow_event_type  offered;
   int              queued_events = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   int              hold_left = 0;
   logic            calm = 1'b0;
   logic            hold_request = 1'b0;

   logic [MARKER_W-1:0]      marker_cfg = MARKER_RESET;
   bit                       slot_used [RING];
   logic [SEQ_W-1:0]         slot_seqno [RING];
   longint                   slot_sent [RING];
   longint                   slot_rcvd [RING];
   int unsigned              pkt_total = 0;
   int unsigned              pair_total = 0;
   int unsigned              reported_total = 0;
   longint                   spread_lo = SPREAD_TOP;
   longint                   spread_hi = SPREAD_BOTTOM;
   longint                   last_loss = 0;
   bit                       window_fresh = 1'b1;
   int                       peak_seen = -1;

   always #10 clock = ~clock;

   function automatic longint clamp_diff(longint a, longint b);
      logic [64:0] wide;
      wide = {a[63], a} - {b[63], b};
      if (wide[64] != wide[63]) begin
         return wide[64] ? SPREAD_BOTTOM : SPREAD_TOP;
      end
      return wide[63:0];
   endfunction

   task automatic note_pair(longint spread);
      if (pair_total != CNT_SAT) begin
         pair_total++;
      end
      if (spread < spread_lo) begin
         spread_lo = spread;
      end
      if (spread > spread_hi) begin
         spread_hi = spread;
      end
   endtask

   task automatic apply_event(flow_event_type ev);
      int unsigned     home;
      int unsigned     up;
      int unsigned     down;
      longint          pkts;
      longint          pairs;
      longint          loss_now;
      longint          loss_step;
      logic [63:0]     span;
      flow_report_type rep;
      if (ev.op == OP_PACKET) begin
         if (ev.marker == marker_cfg) begin
            if (window_fresh) begin
               window_fresh = 1'b0;
               spread_lo = SPREAD_TOP;
               spread_hi = SPREAD_BOTTOM;
            end
            if (pkt_total != CNT_SAT) begin
               pkt_total++;
            end
            home = ev.seq % RING;
            slot_used[home] = 1'b1;
            slot_seqno[home] = ev.seq;
            slot_sent[home] = ev.sent;
            slot_rcvd[home] = ev.rcvd;
            up = (home + 1) % RING;
            down = (home + RING - 1) % RING;
            if (slot_used[up] && {1'b0, slot_seqno[home]} + 32'd1 == {1'b0, slot_seqno[up]}) begin
               note_pair(clamp_diff(ev.rcvd, slot_sent[up]));
            end
            if (slot_used[down] && {1'b0, slot_seqno[down]} + 32'd1 == {1'b0, slot_seqno[home]}) begin
               note_pair(clamp_diff(slot_rcvd[down], ev.sent));
            end
         end
      end else if (reported_total != pkt_total) begin
         pkts = pkt_total;
         pairs = pair_total;
         loss_now = pkts - 1 - pairs;
         loss_step = loss_now - last_loss;
         rep.had_pair = (spread_hi >= spread_lo);
         rep.jitter = '0;
         if (rep.had_pair) begin
            span = spread_hi - spread_lo;
            rep.jitter = (span > JIT_SAT) ? JIT_SAT : span[JIT_W-1:0];
            if (peak_seen < int'(rep.jitter)) begin
               peak_seen = int'(rep.jitter);
            end
         end
         rep.total = pkt_total;
         rep.fresh = pkt_total - reported_total;
         rep.loss = loss_now[LOSS_W-1:0];
         rep.loss_delta = loss_step[DLOSS_W-1:0];
         rep.peak = peak_seen;
         last_loss = loss_now;
         window_fresh = 1'b1;
         reported_total = pkt_total;
         expected_reports.push_back(rep);
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 100) begin
         $display("tb: mismatch in %s at cycle %0d: got %h, expected %h",
                  what, cycle_count, got, want);
      end
      mismatches++;
   endtask

   task automatic check_report();
      flow_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected report", rsp_bus.total_packets, '0);
      end else begin
         want = expected_reports.pop_front();
         if (rsp_bus.total_packets !== want.total)
            report_mismatch("total_packets", rsp_bus.total_packets, want.total);
         if (rsp_bus.new_packets !== want.fresh)
            report_mismatch("new_packets", rsp_bus.new_packets, want.fresh);
         if (rsp_bus.loss !== want.loss)
            report_mismatch("loss", rsp_bus.loss, want.loss);
         if (rsp_bus.loss_change !== want.loss_delta)
            report_mismatch("loss_change", rsp_bus.loss_change, want.loss_delta);
         if (rsp_bus.window_jitter !== want.jitter)
            report_mismatch("window_jitter", rsp_bus.window_jitter, want.jitter);
         if (rsp_bus.peak_jitter !== want.peak)
            report_mismatch("peak_jitter", rsp_bus.peak_jitter, want.peak);
         if (rsp_bus.window_had_pair !== want.had_pair)
            report_mismatch("window_had_pair", rsp_bus.window_had_pair, want.had_pair);
      end
   endtask

   // The driver offers the next pending transaction and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_event(offered);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
               offered = pending_events.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.operation <= offered.op;
               req_bus.seq_num   <= offered.seq;
               req_bus.marker    <= offered.marker;
               req_bus.send_time <= offered.sent;
               req_bus.recv_time <= offered.rcvd;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || $urandom_range(99) >= 20;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_report();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_event(logic [0:0] op, logic [SEQ_W-1:0] seq, logic [MARKER_W-1:0] marker,
                             longint sent, longint rcvd);
      flow_event_type ev;
      ev.op = op;
      ev.seq = seq;
      ev.marker = marker;
      ev.sent = sent;
      ev.rcvd = rcvd;
      pending_events.push_back(ev);
      queued_events++;
   endtask

   task automatic push_tick();
      push_event(OP_TICK, SEQ_W'($urandom), $urandom, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic push_packet(logic [SEQ_W-1:0] seq, longint sent, longint rcvd);
      push_event(OP_PACKET, seq, marker_cfg, sent, rcvd);
   endtask

   task automatic add_flow(int count, int tick_pct);
      logic [SEQ_W-1:0]    base_seq;
      logic [MARKER_W-1:0] marker;
      logic [63:0]         jitter_mask;
      longint              start_us;
      longint              gap_us;
      longint              delay_us;
      longint              send_us;
      int                  order[$];
      int                  swap;
      base_seq = ($urandom_range(9) == 0) ? 31'h7FFF_FFFF - SEQ_W'($urandom_range(count))
                                          : SEQ_W'($urandom);
      start_us = $signed({$urandom, $urandom}) >>> $urandom_range(2, 62);
      gap_us = $urandom_range(1, 20000);
      delay_us = $urandom_range(0, 200000);
      jitter_mask = (64'd1 << $urandom_range(0, 36)) - 64'd1;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) >= 5) order.push_back(k);
         if ($urandom_range(99) < 2) order.push_back(k);
      end
      for (int k = 0; k + 1 < order.size(); k++) begin
         if ($urandom_range(9) == 0) begin
            swap = order[k];
            order[k] = order[k + 1];
            order[k + 1] = swap;
         end
      end
      foreach (order[i]) begin
         send_us = start_us + longint'(order[i]) * gap_us;
         marker = ($urandom_range(99) < 3) ? marker_cfg ^ (32'd1 << $urandom_range(31))
                                           : marker_cfg;
         push_event(OP_PACKET, base_seq + SEQ_W'(order[i]), marker, send_us,
                    send_us + delay_us + longint'({$urandom, $urandom} & jitter_mask));
         if ($urandom_range(99) < tick_pct) push_tick();
      end
   endtask

   task automatic add_noise(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 15) begin
            push_tick();
         end else begin
            push_event(OP_PACKET,
                       $urandom_range(1) ? SEQ_W'($urandom) : SEQ_W'($urandom_range(2 * RING - 1)),
                       ($urandom_range(3) == 0) ? $urandom : marker_cfg,
                       {$urandom, $urandom}, {$urandom, $urandom});
         end
      end
   endtask

   task automatic fill_phase(int count, int tick_pct);
      int target;
      target = queued_events + count;
      while (queued_events < target) begin
         if ($urandom_range(99) < 75) add_flow($urandom_range(4, 40), tick_pct);
         else add_noise($urandom_range(1, 10));
      end
   endtask

   task automatic wait_quiet();
      while (pending_events.size() != 0 || req_bus.valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_marker(logic [MARKER_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      marker_cfg = value;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_PACKET;
      req_bus.seq_num = '0;
      req_bus.marker = '0;
      req_bus.send_time = '0;
      req_bus.recv_time = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset marker.
      push_tick();
      push_event(OP_PACKET, 31'd0, MARKER_RESET + 32'd1, 64'sd0, 64'sd100);
      push_tick();
      push_packet(31'd0, 64'sd0, 64'sd100);
      push_tick();
      push_packet(31'd1, 64'sd1000, 64'sd1100);
      push_packet(31'd2, 64'sd1900, 64'sd2500);
      push_tick();
      push_packet(31'h7FFF_FFFF, SPREAD_TOP, SPREAD_TOP);
      push_packet(31'h7FFF_FFFE, SPREAD_BOTTOM, SPREAD_BOTTOM);
      push_packet(31'd0, SPREAD_BOTTOM, SPREAD_TOP);
      push_packet(31'd100, 64'sd5, SPREAD_TOP);
      push_packet(31'd101, SPREAD_BOTTOM, 64'sd7);
      push_tick();
      push_tick();
      push_packet(31'd8193, 64'sd10, 64'sd20);
      push_packet(31'd8194, 64'sd30, 64'sd45);
      push_tick();
      push_packet(31'd8194, 64'sd31, 64'sd50);
      push_event(OP_PACKET, 31'd8195, ~MARKER_RESET, 64'sd40, 64'sd60);
      push_tick();
      wait_quiet();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_marker(32'h0000_0000);
            1: write_marker(32'hFFFF_FFFF);
            5: write_marker(MARKER_RESET);
            default: write_marker($urandom);
         endcase
         calm <= (phase == 1);
         if (phase == 2) begin
            hold_request <= 1'b1;
            fill_phase(PHASE_EVENTS, 50);
            @(posedge clock);
            hold_request <= 1'b0;
         end else if (phase == 3) begin
            fill_phase(PHASE_EVENTS / 2, 10);
            wait_quiet();
            fill_phase(PHASE_EVENTS / 2, 10);
         end else begin
            fill_phase(PHASE_EVENTS, 10);
         end
         wait_quiet();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/pjlm_pkg.sv
rtl/pjlm_req_if.sv
rtl/pjlm_rsp_if.sv
rtl/pjlm_index.sv
rtl/pjlm_ring.sv
rtl/pjlm_stats.sv
rtl/pjlm_report.sv
rtl/packet_jitter_loss_monitor.sv
bench/testbench.sv
